// File: design/cluster_access_profiler_defines.svh
// Assertion macros used by cap_back.
`ifndef CLUSTER_ACCESS_PROFILER_DEFINES_SVH
`define CLUSTER_ACCESS_PROFILER_DEFINES_SVH

`ifndef SYNTHESIS
`define CAP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cap: assertion failed");
`define CAP_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("cap: forbidden condition seen");
`else
`define CAP_ASSERT(lbl, clk, rst, prop)
`define CAP_NEVER(lbl, clk, rst, expr)
`endif

`endif

// File: design/cap_pkg.sv
package cap_pkg;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  handle;
    logic [4:0]  file_id;
    logic [23:0] byte_count;
    logic [39:0] seek_offset;
    logic [9:0]  cluster_index;
  } item_t;

  typedef struct packed {
    logic        handle_known;
    logic [4:0]  file_ref;
    logic [31:0] open_total;
    logic [31:0] seek_total;
    logic [31:0] uncached_seeks;
    logic [31:0] wasted_seeks;
    logic [31:0] read_calls;
    logic [31:0] zero_reads;
    logic [47:0] bytes_total;
    logic [31:0] clusters_touched;
    logic [10:0] unique_clusters;
    logic [15:0] cluster_hits;
  } result_t;

  typedef struct packed {
    logic [31:0] open_total;
    logic [31:0] seek_total;
    logic [31:0] uncached_seeks;
    logic [31:0] wasted_seeks;
    logic [31:0] read_calls;
    logic [31:0] zero_reads;
    logic [47:0] bytes_total;
    logic [31:0] clusters_touched;
    logic [10:0] unique_clusters;
  } counters_t;

  localparam logic [2:0] ACT_OPEN  = 3'd0;
  localparam logic [2:0] ACT_READ  = 3'd1;
  localparam logic [2:0] ACT_SEEK  = 3'd2;
  localparam logic [2:0] ACT_CLOSE = 3'd3;
  localparam logic [2:0] ACT_QUERY = 3'd4;

  localparam logic [2:0] CL_OPEN   = 3'd0;
  localparam logic [2:0] CL_READ   = 3'd1;
  localparam logic [2:0] CL_SEEK   = 3'd2;
  localparam logic [2:0] CL_CLOSE  = 3'd3;
  localparam logic [2:0] CL_QUERY  = 3'd4;
  localparam logic [2:0] CL_IGNORE = 3'd5;

  typedef struct packed {
    logic [2:0] cls;
    item_t      item;
  } cmd_t;

  localparam logic [4:0] CSL_RESET = 5'd16;
  localparam logic [4:0] CSL_MIN   = 5'd9;
  localparam logic [4:0] CSL_MAX   = 5'd24;

endpackage

// File: design/cap_ram.sv
module cap_ram #(
  parameter int W = 16,
  parameter int D = 1024
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                   wdata,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                   rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/cap_fifo.sv
// Two-entry queue.
module cap_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);
  logic [W-1:0] slot [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;
  logic         do_wr;
  logic         do_rd;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slot[rp];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_wr) wp <= ~wp;
      if (do_rd) rp <= ~rp;
      if (do_wr && !do_rd) cnt <= cnt + 2'd1;
      else if (do_rd && !do_wr) cnt <= cnt - 2'd1;
    end
  end
endmodule

// File: design/cap_front.sv
// Accepts requests, tags them with a class and queues them for the back end.
module cap_front #(
  parameter int HANDLE_SLOTS = 16,
  parameter int FILE_SLOTS   = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  cap_pkg::item_t item,
  input  logic           hold,
  input  logic           cmd_rd,
  output cap_pkg::cmd_t  cmd,
  output logic           cmd_empty
);
  cap_pkg::cmd_t cmd_in;
  logic          q_full;
  logic          fid_ok;
  logic          hdl_ok;

  assign fid_ok = 32'(item.file_id) < 32'(FILE_SLOTS);
  assign hdl_ok = 32'(item.handle) < 32'(HANDLE_SLOTS);

  always_comb begin
    cmd_in.item = item;
    unique case (item.action)
      cap_pkg::ACT_OPEN:  cmd_in.cls = (fid_ok && hdl_ok) ? cap_pkg::CL_OPEN : cap_pkg::CL_IGNORE;
      cap_pkg::ACT_READ:  cmd_in.cls = hdl_ok ? cap_pkg::CL_READ : cap_pkg::CL_IGNORE;
      cap_pkg::ACT_SEEK:  cmd_in.cls = hdl_ok ? cap_pkg::CL_SEEK : cap_pkg::CL_IGNORE;
      cap_pkg::ACT_CLOSE: cmd_in.cls = hdl_ok ? cap_pkg::CL_CLOSE : cap_pkg::CL_IGNORE;
      cap_pkg::ACT_QUERY: cmd_in.cls = fid_ok ? cap_pkg::CL_QUERY : cap_pkg::CL_IGNORE;
      default:            cmd_in.cls = cap_pkg::CL_IGNORE;
    endcase
  end

  // held full while the stores are being cleared
  assign full = q_full || hold;

  cap_fifo #(.W($bits(cap_pkg::cmd_t))) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .wr    (push && !full),
    .wdata (cmd_in),
    .full  (q_full),
    .rd    (cmd_rd),
    .rdata (cmd),
    .empty (cmd_empty)
  );
endmodule

// File: design/cap_back.sv
`include "cluster_access_profiler_defines.svh"

// Executes queued requests against the handle table, counter store and hit store.
module cap_back #(
  parameter int HANDLE_SLOTS      = 16,
  parameter int FILE_SLOTS        = 32,
  parameter int CLUSTERS_PER_FILE = 1024,
  parameter int HIT_MAX           = 65535
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [4:0]       cfg_data,
  input  cap_pkg::cmd_t    cmd,
  input  logic             cmd_empty,
  output logic             cmd_rd,
  input  logic             res_full,
  output logic             res_push,
  output cap_pkg::result_t res,
  output logic             clearing
);
  localparam int HW        = HANDLE_SLOTS > 1 ? $clog2(HANDLE_SLOTS) : 1;
  localparam int FW        = FILE_SLOTS > 1 ? $clog2(FILE_SLOTS) : 1;
  localparam int CW        = $clog2(CLUSTERS_PER_FILE);
  localparam int HIT_DEPTH = FILE_SLOTS * CLUSTERS_PER_FILE;
  localparam int HAW       = $clog2(HIT_DEPTH);
  localparam int CTW       = $bits(cap_pkg::counters_t);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CRD    = 4'd1;
  localparam logic [3:0] S_PREP   = 4'd2;
  localparam logic [3:0] S_RUN    = 4'd3;
  localparam logic [3:0] S_WALK_A = 4'd4;
  localparam logic [3:0] S_WALK_D = 4'd5;
  localparam logic [3:0] S_SEEK_A = 4'd6;
  localparam logic [3:0] S_SEEK_D = 4'd7;
  localparam logic [3:0] S_QRY_A  = 4'd8;
  localparam logic [3:0] S_QRY_D  = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  function automatic logic [31:0] inc32(input logic [31:0] x);
    inc32 = (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

  logic [4:0]  csl;
  logic [4:0]  shamt;
  logic [3:0]  state;
  logic [HAW:0] clr;

  // handle table
  logic        hvalid [HANDLE_SLOTS];
  logic [4:0]  hfile  [HANDLE_SLOTS];
  logic [39:0] rstart [HANDLE_SLOTS];
  logic [39:0] rlen   [HANDLE_SLOTS];
  logic [31:0] rreads [HANDLE_SLOTS];

  cap_pkg::cmd_t        cur;
  logic [HW-1:0]        hidx;
  logic [4:0]           f;
  logic [39:0]          rs;
  logic [39:0]          rl;
  logic [31:0]          rr;
  cap_pkg::counters_t   fc;
  logic [HAW-1:0]       base;
  logic [40:0]          endsum;
  logic [39:0]          cl;
  logic [39:0]          first;
  logic [40:0]          last;
  logic [CW-1:0]        wcur;
  logic [CW-1:0]        wend;
  logic [15:0]          hits;

  logic [HW-1:0]        hidx_c;
  logic [4:0]           fsel;
  logic                 take;
  logic                 drop;
  logic                 is_seek;

  logic                 cnt_we;
  logic [FW-1:0]        cnt_waddr;
  logic [CTW-1:0]       cnt_wdata;
  logic [CTW-1:0]       cnt_rdata;
  logic                 hit_we;
  logic [HAW-1:0]       hit_waddr;
  logic [15:0]          hit_wdata;
  logic [HAW-1:0]       hit_raddr;
  logic [15:0]          hit_rdata;

  logic [40:0]          span;
  logic [41:0]          ct_sum;
  logic [48:0]          bytes_sum;
  logic [40:0]          len_sum;

  assign cfg_ready = 1'b1;
  assign clearing  = (clr != (HAW + 1)'(HIT_DEPTH));
  assign shamt     = (csl < cap_pkg::CSL_MIN) ? cap_pkg::CSL_MIN :
                     (csl > cap_pkg::CSL_MAX) ? cap_pkg::CSL_MAX : csl;
  assign is_seek   = (cur.cls == cap_pkg::CL_SEEK);

  assign hidx_c = HW'(cmd.item.handle);
  assign fsel   = (cmd.cls == cap_pkg::CL_OPEN || cmd.cls == cap_pkg::CL_QUERY) ?
                  cmd.item.file_id : hfile[hidx_c];
  assign take   = (state == S_IDLE) && !clearing && !cmd_empty && !res_full;
  assign drop   = (cmd.cls == cap_pkg::CL_IGNORE) ||
                  ((cmd.cls == cap_pkg::CL_READ || cmd.cls == cap_pkg::CL_SEEK ||
                    cmd.cls == cap_pkg::CL_CLOSE) && !hvalid[hidx_c]);
  assign cmd_rd   = take;
  assign res_push = (take && drop) || (state == S_FIN);

  assign span      = last - {1'b0, first} + 41'd1;
  assign ct_sum    = {10'd0, fc.clusters_touched} + {1'b0, span};
  assign bytes_sum = {1'b0, fc.bytes_total} + 49'(cur.item.byte_count);
  assign len_sum   = {1'b0, rl} + 41'(cur.item.byte_count);

  always_comb begin
    res = '0;
    if (state == S_FIN) begin
      res.handle_known      = 1'b1;
      res.file_ref          = f;
      res.open_total        = fc.open_total;
      res.seek_total        = fc.seek_total;
      res.uncached_seeks    = fc.uncached_seeks;
      res.wasted_seeks      = fc.wasted_seeks;
      res.read_calls        = fc.read_calls;
      res.zero_reads        = fc.zero_reads;
      res.bytes_total       = fc.bytes_total;
      res.clusters_touched  = fc.clusters_touched;
      res.unique_clusters   = fc.unique_clusters;
      res.cluster_hits      = hits;
    end
  end

  // store ports
  always_comb begin
    cnt_we    = clearing ? (clr < (HAW + 1)'(FILE_SLOTS)) : (state == S_FIN);
    cnt_waddr = clearing ? clr[FW-1:0] : FW'(f);
    cnt_wdata = clearing ? '0 : fc;
    hit_we    = clearing || ((state == S_WALK_D) && (hit_rdata < 16'(HIT_MAX)));
    hit_waddr = clearing ? clr[HAW-1:0] : base + HAW'(wcur);
    hit_wdata = clearing ? 16'd0 : hit_rdata + 16'd1;
    case (state)
      S_SEEK_A: hit_raddr = base + HAW'(cl);
      S_QRY_A:  hit_raddr = base + HAW'(cur.item.cluster_index);
      default:  hit_raddr = base + HAW'(wcur);
    endcase
  end

  cap_ram #(.W(CTW), .D(FILE_SLOTS)) u_cnt (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (FW'(fsel)),
    .rdata (cnt_rdata)
  );

  cap_ram #(.W(16), .D(HIT_DEPTH)) u_hit (
    .clk   (clk),
    .we    (hit_we),
    .waddr (hit_waddr),
    .wdata (hit_wdata),
    .raddr (hit_raddr),
    .rdata (hit_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      csl <= cap_pkg::CSL_RESET;
      clr <= '0;
    end else begin
      if (cfg_valid) csl <= cfg_data;
      if (clearing) clr <= clr + (HAW + 1)'(1);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < HANDLE_SLOTS; i++) begin
        hvalid[i] <= 1'b0;
        rreads[i] <= 32'd0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take && !drop) begin
            cur   <= cmd;
            hidx  <= hidx_c;
            f     <= fsel;
            rs    <= rstart[hidx_c];
            rl    <= rlen[hidx_c];
            rr    <= rreads[hidx_c];
            state <= S_CRD;
          end
        end
        S_CRD: begin
          fc     <= cnt_rdata;
          base   <= HAW'(32'(f) * CLUSTERS_PER_FILE);
          endsum <= {1'b0, rs} + {1'b0, rl} - 41'd1;
          cl     <= cur.item.seek_offset >> shamt;
          hits   <= 16'd0;
          state  <= S_PREP;
        end
        S_PREP: begin
          first <= rs >> shamt;
          last  <= endsum >> shamt;
          case (cur.cls)
            cap_pkg::CL_OPEN: begin
              fc.open_total <= inc32(fc.open_total);
              state         <= S_FIN;
            end
            cap_pkg::CL_READ: begin
              fc.read_calls  <= inc32(fc.read_calls);
              fc.bytes_total <= bytes_sum[48] ? 48'hFFFF_FFFF_FFFF : bytes_sum[47:0];
              if (cur.item.byte_count == 24'd0) fc.zero_reads <= inc32(fc.zero_reads);
              state <= S_FIN;
            end
            cap_pkg::CL_QUERY: state <= S_QRY_A;
            default:           state <= S_RUN;
          endcase
        end
        S_RUN: begin
          if (rl != 40'd0) begin
            fc.clusters_touched <= (ct_sum > 42'hFFFF_FFFF) ? 32'hFFFF_FFFF : ct_sum[31:0];
            if (first < 40'(CLUSTERS_PER_FILE)) begin
              wcur  <= CW'(first);
              wend  <= (last < 41'(CLUSTERS_PER_FILE)) ? CW'(last) : CW'(CLUSTERS_PER_FILE - 1);
              state <= S_WALK_A;
            end else begin
              state <= is_seek ? S_SEEK_A : S_FIN;
            end
          end else begin
            if (rr == 32'd0) fc.wasted_seeks <= inc32(fc.wasted_seeks);
            state <= is_seek ? S_SEEK_A : S_FIN;
          end
        end
        S_WALK_A: state <= S_WALK_D;
        S_WALK_D: begin
          if (hit_rdata == 16'd0) fc.unique_clusters <= fc.unique_clusters + 11'd1;
          if (wcur == wend) begin
            state <= is_seek ? S_SEEK_A : S_FIN;
          end else begin
            wcur  <= wcur + CW'(1);
            state <= S_WALK_A;
          end
        end
        S_SEEK_A: state <= S_SEEK_D;
        S_SEEK_D: begin
          fc.seek_total <= inc32(fc.seek_total);
          if (cl >= 40'(CLUSTERS_PER_FILE) || hit_rdata == 16'd0) begin
            fc.uncached_seeks <= inc32(fc.uncached_seeks);
          end
          state <= S_FIN;
        end
        S_QRY_A: state <= S_QRY_D;
        S_QRY_D: begin
          if (32'(cur.item.cluster_index) < 32'(CLUSTERS_PER_FILE)) hits <= hit_rdata;
          state <= S_FIN;
        end
        S_FIN: begin
          case (cur.cls)
            cap_pkg::CL_OPEN: begin
              hvalid[hidx] <= 1'b1;
              hfile[hidx]  <= f;
              rstart[hidx] <= 40'd0;
              rlen[hidx]   <= 40'd0;
            end
            cap_pkg::CL_READ: begin
              rreads[hidx] <= inc32(rr);
              rlen[hidx]   <= len_sum[40] ? 40'hFF_FFFF_FFFF : len_sum[39:0];
            end
            cap_pkg::CL_SEEK: begin
              rlen[hidx]   <= 40'd0;
              rstart[hidx] <= cur.item.seek_offset;
              rreads[hidx] <= 32'd0;
            end
            default: ;
          endcase
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CAP_ASSERT(a_clear_no_take, clk, rst, clearing |-> !cmd_rd)
  `CAP_ASSERT(a_push_room, clk, rst, res_push |-> !res_full)
  `CAP_ASSERT(a_walk_bound, clk, rst, (state == S_WALK_D) |-> (wcur <= wend))
  `CAP_NEVER(a_hit_write_idle, clk, rst, hit_we && (state == S_IDLE) && !clearing)
endmodule

// File: design/cluster_access_profiler.sv
// channel   | handshake           | payload
// ----------+---------------------+----------------------
// request   | push / full         | item   (item_t)
// result    | pop / empty         | result (result_t)
// config    | cfg_valid/cfg_ready | cfg_data (cluster_size_log2)
//
// Open and read pass S_CRD, S_PREP and S_FIN; query adds S_QRY_A/D, close adds S_RUN and
// S_WALK_A/D per covered cluster, seek adds S_SEEK_A/D; ignored requests end in S_IDLE.
// Each covered cluster needs a registered read of its hit count before the write-back.
// After reset the hit and counter stores are cleared, all FILE_SLOTS * CLUSTERS_PER_FILE
// hit-store entries (32768 by default); full stays high meanwhile, config writes are taken.
// Two-entry queues on the request and result sides let either side stall independently.
module cluster_access_profiler #(
  parameter int HANDLE_SLOTS      = 16,
  parameter int FILE_SLOTS        = 32,
  parameter int CLUSTERS_PER_FILE = 1024,
  parameter int HIT_MAX           = 65535
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  cap_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output cap_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [4:0]       cfg_data
);
  cap_pkg::cmd_t    cmd;
  logic             cmd_empty;
  logic             cmd_rd;
  logic             res_full;
  logic             res_push;
  cap_pkg::result_t res;
  logic             clearing;

  cap_front #(.HANDLE_SLOTS(HANDLE_SLOTS), .FILE_SLOTS(FILE_SLOTS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .hold      (clearing),
    .cmd_rd    (cmd_rd),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  cap_back #(
    .HANDLE_SLOTS      (HANDLE_SLOTS),
    .FILE_SLOTS        (FILE_SLOTS),
    .CLUSTERS_PER_FILE (CLUSTERS_PER_FILE),
    .HIT_MAX           (HIT_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_rd    (cmd_rd),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res),
    .clearing  (clearing)
  );

  cap_fifo #(.W($bits(cap_pkg::result_t))) u_resq (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res),
    .full  (res_full),
    .rd    (pop),
    .rdata (result),
    .empty (empty)
  );
endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int NH = 16;
  localparam int NF = 32;
  localparam int NC = 1024;
  localparam int HITS_TOP = 65535;
  localparam int STALL_LIMIT = 120000;
  localparam longint unsigned M32 = 64'hFFFF_FFFF;
  localparam longint unsigned M40 = 64'hFF_FFFF_FFFF;
  localparam longint unsigned M48 = 64'hFFFF_FFFF_FFFF;

  logic clk, rst;
  logic push, full, empty, pop, cfg_valid, cfg_ready;
  logic [4:0] cfg_data;
  cap_pkg::item_t item;
  cap_pkg::result_t result;

  cluster_access_profiler dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // profiler state as predicted
  logic [4:0]      size_log2;
  bit              slot_open [NH];
  logic [4:0]      slot_file [NH];
  longint unsigned slot_start [NH];
  longint unsigned slot_len [NH];
  longint unsigned slot_reads [NH];
  longint unsigned open_n [NF], seek_n [NF], uncached_n [NF], needless_n [NF];
  longint unsigned reads_n [NF], empties_n [NF], bytes_n [NF], touched_n [NF];
  longint unsigned unique_n [NF];
  int unsigned     hit_count [NF][NC];

  cap_pkg::result_t pending_results[$];
  int errors = 0;
  int requests_sent = 0;
  int results_seen = 0;
  bit calm = 0;

  function automatic longint unsigned sat(longint unsigned a, longint unsigned b,
                                          longint unsigned top);
    if (a >= top || b >= top - a) return top;
    return a + b;
  endfunction

  function automatic int unsigned eff_shift();
    if (size_log2 < cap_pkg::CSL_MIN) return 32'(cap_pkg::CSL_MIN);
    if (size_log2 > cap_pkg::CSL_MAX) return 32'(cap_pkg::CSL_MAX);
    return 32'(size_log2);
  endfunction

  function automatic void close_run(int h);
    int f;
    int unsigned s;
    longint unsigned lo, hi, c;
    f = int'(slot_file[h]);
    if (slot_len[h] != 0) begin
      s = eff_shift();
      lo = slot_start[h] >> s;
      hi = (slot_start[h] + slot_len[h] - 1) >> s;
      touched_n[f] = sat(touched_n[f], hi - lo + 1, M32);
      if (lo < NC) begin
        if (hi >= NC) hi = 64'(NC - 1);
        for (c = lo; c <= hi; c++) begin
          if (hit_count[f][c] == 0) unique_n[f]++;
          if (hit_count[f][c] < HITS_TOP) hit_count[f][c]++;
        end
      end
    end else if (slot_reads[h] == 0) begin
      needless_n[f] = sat(needless_n[f], 1, M32);
    end
  endfunction

  function automatic cap_pkg::result_t file_stats(int f, int unsigned hits);
    cap_pkg::result_t r;
    r.handle_known = 1'b1;
    r.file_ref = 5'(f);
    r.open_total = 32'(open_n[f]);
    r.seek_total = 32'(seek_n[f]);
    r.uncached_seeks = 32'(uncached_n[f]);
    r.wasted_seeks = 32'(needless_n[f]);
    r.read_calls = 32'(reads_n[f]);
    r.zero_reads = 32'(empties_n[f]);
    r.bytes_total = 48'(bytes_n[f]);
    r.clusters_touched = 32'(touched_n[f]);
    r.unique_clusters = 11'(unique_n[f]);
    r.cluster_hits = 16'(hits);
    return r;
  endfunction

  function automatic cap_pkg::result_t profile_event(cap_pkg::item_t it);
    cap_pkg::result_t r;
    int h, f;
    longint unsigned cl;
    r = '0;
    h = int'(it.handle);
    case (it.action)
      cap_pkg::ACT_OPEN: begin
        f = int'(it.file_id);
        open_n[f] = sat(open_n[f], 1, M32);
        slot_open[h] = 1;
        slot_file[h] = 5'(f);
        slot_start[h] = 0;
        slot_len[h] = 0;
        r = file_stats(f, 0);
      end
      cap_pkg::ACT_QUERY:
        r = file_stats(int'(it.file_id), hit_count[it.file_id][it.cluster_index]);
      cap_pkg::ACT_READ, cap_pkg::ACT_SEEK, cap_pkg::ACT_CLOSE: if (slot_open[h]) begin
        f = int'(slot_file[h]);
        if (it.action == cap_pkg::ACT_READ) begin
          slot_reads[h] = sat(slot_reads[h], 1, M32);
          slot_len[h] = sat(slot_len[h], 64'(it.byte_count), M40);
          reads_n[f] = sat(reads_n[f], 1, M32);
          bytes_n[f] = sat(bytes_n[f], 64'(it.byte_count), M48);
          if (it.byte_count == 0) empties_n[f] = sat(empties_n[f], 1, M32);
        end else if (it.action == cap_pkg::ACT_SEEK) begin
          cl = 64'(it.seek_offset) >> eff_shift();
          close_run(h);
          slot_len[h] = 0;
          slot_start[h] = 64'(it.seek_offset);
          slot_reads[h] = 0;
          seek_n[f] = sat(seek_n[f], 1, M32);
          // target checked after the old run has been counted
          if (cl >= NC || hit_count[f][cl] == 0) uncached_n[f] = sat(uncached_n[f], 1, M32);
        end else begin
          close_run(h);
        end
        r = file_stats(f, 0);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles with no handshake at all
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle = 0;
      else idle++;
      if (idle >= STALL_LIMIT) begin
        $display("%0t: timeout, no progress for %0d cycles", $time, idle);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result side
  initial begin
    int stall;
    cap_pkg::result_t want;
    stall = 0;
    pop = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: %p", $time, result);
        end else begin
          want = pending_results.pop_front();
          if (result.handle_known !== want.handle_known)
            $display("%0t: handle_known exp %0d got %0d", $time, want.handle_known,
                     result.handle_known);
          if (result.file_ref !== want.file_ref)
            $display("%0t: file_ref exp %0d got %0d", $time, want.file_ref, result.file_ref);
          if (result.open_total !== want.open_total)
            $display("%0t: open_total exp %0d got %0d", $time, want.open_total,
                     result.open_total);
          if (result.seek_total !== want.seek_total)
            $display("%0t: seek_total exp %0d got %0d", $time, want.seek_total,
                     result.seek_total);
          if (result.uncached_seeks !== want.uncached_seeks)
            $display("%0t: uncached_seeks exp %0d got %0d", $time, want.uncached_seeks,
                     result.uncached_seeks);
          if (result.wasted_seeks !== want.wasted_seeks)
            $display("%0t: wasted_seeks exp %0d got %0d", $time, want.wasted_seeks,
                     result.wasted_seeks);
          if (result.read_calls !== want.read_calls)
            $display("%0t: read_calls exp %0d got %0d", $time, want.read_calls,
                     result.read_calls);
          if (result.zero_reads !== want.zero_reads)
            $display("%0t: zero_reads exp %0d got %0d", $time, want.zero_reads,
                     result.zero_reads);
          if (result.bytes_total !== want.bytes_total)
            $display("%0t: bytes_total exp %0d got %0d", $time, want.bytes_total,
                     result.bytes_total);
          if (result.clusters_touched !== want.clusters_touched)
            $display("%0t: clusters_touched exp %0d got %0d", $time, want.clusters_touched,
                     result.clusters_touched);
          if (result.unique_clusters !== want.unique_clusters)
            $display("%0t: unique_clusters exp %0d got %0d", $time, want.unique_clusters,
                     result.unique_clusters);
          if (result.cluster_hits !== want.cluster_hits)
            $display("%0t: cluster_hits exp %0d got %0d", $time, want.cluster_hits,
                     result.cluster_hits);
          if (result !== want) errors++;
        end
      end
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        stall = gap_len();
      end
    end
  end

  task automatic send_request(cap_pkg::item_t it, bit typed, cap_pkg::result_t typed_exp);
    int g;
    cap_pkg::result_t r;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    r = profile_event(it);
    pending_results.push_back(typed ? typed_exp : r);
    requests_sent++;
  endtask

  task automatic write_size(logic [4:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_log2 = v;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic cap_pkg::item_t mk(logic [2:0] a, int h, int f, logic [23:0] b,
                                        logic [39:0] o, int ci);
    cap_pkg::item_t it;
    it.action = a;
    it.handle = 4'(h);
    it.file_id = 5'(f);
    it.byte_count = b;
    it.seek_offset = o;
    it.cluster_index = 10'(ci);
    return it;
  endfunction

  function automatic cap_pkg::item_t random_request();
    cap_pkg::item_t it;
    int r, s;
    longint unsigned span;
    s = int'(eff_shift());
    it = mk(cap_pkg::ACT_READ, $urandom_range(0, NH - 1), $urandom_range(0, NF - 1),
            24'($urandom), 40'({$urandom, $urandom}), $urandom_range(0, NC - 1));
    // keep most traffic on a few files so clusters get shared hits
    if ($urandom_range(0, 3) != 0) it.file_id = 5'($urandom_range(0, 3));
    span = (64'd4 << s) + 1;
    if ($urandom_range(0, 19) != 0) begin
      it.byte_count = ({$urandom, $urandom} % span) > 64'hFF_FFFF ? 24'hFF_FFFF
                      : 24'(({$urandom, $urandom} % span));
      it.seek_offset = 40'((64'($urandom_range(0, NC + 40)) << s) +
                           ({$urandom, $urandom} % (64'd1 << s)));
      if ($urandom_range(0, 1)) it.cluster_index = 10'($urandom_range(0, 40));
    end
    r = $urandom_range(0, 99);
    if (r < 10) it.action = cap_pkg::ACT_OPEN;
    else if (r < 45) it.action = cap_pkg::ACT_READ;
    else if (r < 65) it.action = cap_pkg::ACT_SEEK;
    else if (r < 75) it.action = cap_pkg::ACT_CLOSE;
    else if (r < 92) it.action = cap_pkg::ACT_QUERY;
    else it.action = 3'($urandom_range(5, 7));
    return it;
  endfunction

  typedef struct {
    cap_pkg::item_t   it;
    bit               typed;
    cap_pkg::result_t r;
  } dir_row_t;

  function automatic cap_pkg::result_t known_only(int f, int opens);
    cap_pkg::result_t r;
    r = '0;
    r.handle_known = 1'b1;
    r.file_ref = 5'(f);
    r.open_total = 32'(opens);
    return r;
  endfunction

  initial begin
    dir_row_t rows[$];
    logic [4:0] sizes[$];
    int total_random;
    push = 0;
    item = '0;
    cfg_valid = 0;
    cfg_data = cap_pkg::CSL_RESET;
    rst = 1;
    size_log2 = cap_pkg::CSL_RESET;
    foreach (slot_open[i]) begin
      slot_open[i] = 0; slot_file[i] = 0; slot_start[i] = 0; slot_len[i] = 0;
      slot_reads[i] = 0;
    end
    foreach (open_n[i]) begin
      open_n[i] = 0; seek_n[i] = 0; uncached_n[i] = 0; needless_n[i] = 0;
      reads_n[i] = 0; empties_n[i] = 0; bytes_n[i] = 0; touched_n[i] = 0;
      unique_n[i] = 0;
      for (int c = 0; c < NC; c++) hit_count[i][c] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_size(cap_pkg::CSL_RESET);

    rows.push_back('{mk(cap_pkg::ACT_QUERY, 0, 3, 0, 0, 0), 1, known_only(3, 0)});
    rows.push_back('{mk(3'd5, 1, 1, 24'hFF_FFFF, '1, 1023), 1, '0});
    rows.push_back('{mk(3'd7, 15, 31, 0, 0, 0), 1, '0});
    rows.push_back('{mk(cap_pkg::ACT_READ, 2, 0, 100, 0, 0), 1, '0});
    rows.push_back('{mk(cap_pkg::ACT_CLOSE, 9, 0, 0, 0, 0), 1, '0});
    rows.push_back('{mk(cap_pkg::ACT_OPEN, 15, 31, 0, 0, 0), 1, known_only(31, 1)});
    rows.push_back('{mk(cap_pkg::ACT_READ, 15, 0, 0, 0, 0), 0, '0});         // empty read
    rows.push_back('{mk(cap_pkg::ACT_READ, 15, 0, 24'hFF_FFFF, 0, 0), 0, '0});
    rows.push_back('{mk(cap_pkg::ACT_SEEK, 15, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(cap_pkg::ACT_SEEK, 15, 0, 0, '1, 0), 0, '0});        // seek past store
    rows.push_back('{mk(cap_pkg::ACT_CLOSE, 15, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(cap_pkg::ACT_CLOSE, 15, 0, 0, 0, 0), 0, '0});        // same run again
    rows.push_back('{mk(cap_pkg::ACT_OPEN, 0, 0, 0, 0, 0), 1, known_only(0, 1)});
    rows.push_back('{mk(cap_pkg::ACT_READ, 0, 0, 200000, 0, 0), 0, '0});
    rows.push_back('{mk(cap_pkg::ACT_SEEK, 0, 0, 0, 40'd196608, 0), 0, '0});
    rows.push_back('{mk(cap_pkg::ACT_READ, 0, 0, 1, 0, 0), 0, '0});
    rows.push_back('{mk(cap_pkg::ACT_SEEK, 0, 0, 0, 40'd65536, 0), 0, '0});  // cached target
    rows.push_back('{mk(cap_pkg::ACT_CLOSE, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(cap_pkg::ACT_QUERY, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(cap_pkg::ACT_QUERY, 0, 0, 0, 0, 1023), 0, '0});
    rows.push_back('{mk(cap_pkg::ACT_OPEN, 0, 0, 0, 0, 0), 0, '0});          // reopen keeps reads
    rows.push_back('{mk(cap_pkg::ACT_CLOSE, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(cap_pkg::ACT_QUERY, 7, 31, 0, 0, 3), 0, '0});
    rows.push_back('{mk(3'd6, 15, 0, 0, 0, 0), 1, '0});
    foreach (rows[i]) send_request(rows[i].it, rows[i].typed, rows[i].r);
    drain();

    sizes = '{5'd9, 5'd0, 5'd31, 5'd24, 5'd12, 5'($urandom_range(0, 31))};
    total_random = 0;
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      calm = (p == 3);
      for (int n = 0; n < 200; n++) begin
        send_request(random_request(), 0, '0);
        total_random++;
      end
      drain();
    end
    calm = 0;

    $display("%0d requests (%0d directed, %0d random) over %0d cluster sizes,",
             requests_sent, rows.size(), total_random, sizes.size() + 1);
    $display("%0d results checked, %0d mismatching", results_seen, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
